// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

   localparam int DATA_BITS     = 64;
   localparam int CMD_BITS      = 3;
   localparam int WORD_BITS_DEF = 64;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_MAKE     = 3'd0,
      CMD_SIMPLIFY = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_MUL      = 3'd3,
      CMD_LEQ      = 3'd4,
      CMD_EQ       = 3'd5,
      CMD_MAX      = 3'd6
   } cmd_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL,
      DP_DIV,
      DP_LOAD_PQ,
      DP_EUCLID,
      DP_GCD_OUT,
      DP_MOVE_QUO,
      DP_MOVE_PROD,
      DP_ADD_PROD,
      DP_TAKE,
      DP_SET_FLAG,
      DP_SET_ZERO,
      DP_SET_INF,
      DP_SET_ERR
   } dp_op_type;

   typedef enum logic [3:0] {
      SRC_AN, SRC_AD, SRC_BN, SRC_BD, SRC_P, SRC_Q, SRC_RN, SRC_RD, SRC_G
   } src_type;

   typedef enum logic [2:0] {
      DST_AN, DST_AD, DST_BN, DST_BD, DST_P, DST_Q, DST_RN, DST_RD
   } dst_type;

   typedef struct packed {
      dp_op_type op;
      src_type   src_a;
      src_type   src_b;
      dst_type   dst;
      logic      val;
   } dp_cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic a_zero;
      logic b_zero;
      logic a_inf;
      logic b_inf;
      logic rn_zero;
      logic rd_zero;
      logic q_zero;
      logic p_ge_q;
      logic q_ge_p;
      logic rn_fits;
      logic rd_fits;
   } dp_status_type;

endpackage

// ===== design/rau_datapath.sv =====
// Datapath: operand registers, work registers and a shared shift-add multiplier / divider.
module rau_datapath import rau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   input  logic [DATA_BITS-1:0] req_a_num,
   input  logic [DATA_BITS-1:0] req_a_den,
   input  logic [DATA_BITS-1:0] req_b_num,
   input  logic [DATA_BITS-1:0] req_b_den,
   output dp_status_type        dp_status,
   output logic [DATA_BITS-1:0] res_num,
   output logic [DATA_BITS-1:0] res_den,
   output logic                 res_flag,
   output logic                 res_error
);

   localparam int WD = 2 * WORD_BITS + 1;
   localparam int CW = $clog2(WD + 1);
   localparam logic [WORD_BITS-1:0] INF_W = '1;

   logic [WORD_BITS-1:0] an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic [WD-1:0]        p_ff, q_ff, g_ff, rn_ff, rd_ff, p_in, q_in, g_in, rn_in, rd_in;
   logic                 flag_ff, err_ff, flag_in, err_in;
   logic [WD-1:0]        acc_ff, sh_ff, dv_ff, acc_in, sh_in, dv_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, mul_ff, mul_in;

   logic [WD-1:0] src_a_val, src_b_val, wval;
   logic          wen;
   logic [WD:0]   div_t, div_diff;
   logic          div_ge;

   function automatic logic [WD-1:0] pick(input src_type s,
                                          input logic [WORD_BITS-1:0] an,
                                          input logic [WORD_BITS-1:0] ad,
                                          input logic [WORD_BITS-1:0] bn,
                                          input logic [WORD_BITS-1:0] bd,
                                          input logic [WD-1:0] p,
                                          input logic [WD-1:0] q,
                                          input logic [WD-1:0] rn,
                                          input logic [WD-1:0] rd,
                                          input logic [WD-1:0] g);
      logic [WD-1:0] v;
      case (s)
         SRC_AN:  v = WD'(an);
         SRC_AD:  v = WD'(ad);
         SRC_BN:  v = WD'(bn);
         SRC_BD:  v = WD'(bd);
         SRC_P:   v = p;
         SRC_Q:   v = q;
         SRC_RN:  v = rn;
         SRC_RD:  v = rd;
         SRC_G:   v = g;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign src_a_val = pick(dp_cmd.src_a, an_ff, ad_ff, bn_ff, bd_ff, p_ff, q_ff, rn_ff, rd_ff,
                           g_ff);
   assign src_b_val = pick(dp_cmd.src_b, an_ff, ad_ff, bn_ff, bd_ff, p_ff, q_ff, rn_ff, rd_ff,
                           g_ff);

   // One restoring division step: shift in the next dividend bit and try the divisor.
   assign div_t    = {acc_ff, sh_ff[WD-1]};
   assign div_diff = div_t - {1'b0, dv_ff};
   assign div_ge   = (div_t >= {1'b0, dv_ff});

   assign wen  = (dp_cmd.op == DP_MOVE_QUO) || (dp_cmd.op == DP_MOVE_PROD) ||
                 (dp_cmd.op == DP_ADD_PROD);
   assign wval = (dp_cmd.op == DP_MOVE_QUO)  ? sh_ff :
                 (dp_cmd.op == DP_MOVE_PROD) ? acc_ff : (src_a_val + acc_ff);

   always_comb begin
      an_in   = an_ff;
      ad_in   = ad_ff;
      bn_in   = bn_ff;
      bd_in   = bd_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      g_in    = g_ff;
      rn_in   = rn_ff;
      rd_in   = rd_ff;
      flag_in = flag_ff;
      err_in  = err_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mul_in  = mul_ff;

      if (busy_ff) begin
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
         if (mul_ff) begin
            acc_in = sh_ff[0] ? (acc_ff + dv_ff) : acc_ff;
            dv_in  = dv_ff << 1;
            sh_in  = sh_ff >> 1;
         end else begin
            acc_in = div_ge ? div_diff[WD-1:0] : div_t[WD-1:0];
            sh_in  = {sh_ff[WD-2:0], div_ge};
         end
      end

      case (dp_cmd.op)
         DP_LOAD: begin
            an_in   = req_a_num[WORD_BITS-1:0];
            ad_in   = req_a_den[WORD_BITS-1:0];
            bn_in   = req_b_num[WORD_BITS-1:0];
            bd_in   = req_b_den[WORD_BITS-1:0];
            rn_in   = '0;
            rd_in   = '0;
            flag_in = 1'b0;
            err_in  = 1'b0;
         end
         DP_MUL: begin
            acc_in  = '0;
            sh_in   = src_a_val;
            dv_in   = src_b_val;
            cnt_in  = CW'(WORD_BITS);
            mul_in  = 1'b1;
            busy_in = 1'b1;
         end
         DP_DIV: begin
            acc_in  = '0;
            sh_in   = src_a_val;
            dv_in   = src_b_val;
            cnt_in  = CW'(WD);
            mul_in  = 1'b0;
            busy_in = 1'b1;
         end
         DP_LOAD_PQ: begin
            p_in = src_a_val;
            q_in = src_b_val;
         end
         DP_EUCLID: begin
            p_in = q_ff;
            q_in = acc_ff;
         end
         DP_GCD_OUT: g_in = p_ff;
         DP_TAKE: begin
            rn_in = dp_cmd.val ? WD'(bn_ff) : WD'(an_ff);
            rd_in = dp_cmd.val ? WD'(bd_ff) : WD'(ad_ff);
         end
         DP_SET_FLAG: flag_in = dp_cmd.val;
         DP_SET_ZERO: begin
            rn_in = '0;
            rd_in = WD'(1);
         end
         DP_SET_INF: begin
            rn_in = WD'(INF_W);
            rd_in = WD'(1);
         end
         DP_SET_ERR: begin
            rn_in   = '0;
            rd_in   = '0;
            flag_in = 1'b0;
            err_in  = 1'b1;
         end
         default: ;
      endcase

      if (wen) begin
         case (dp_cmd.dst)
            DST_AN:  an_in = wval[WORD_BITS-1:0];
            DST_AD:  ad_in = wval[WORD_BITS-1:0];
            DST_BN:  bn_in = wval[WORD_BITS-1:0];
            DST_BD:  bd_in = wval[WORD_BITS-1:0];
            DST_P:   p_in  = wval;
            DST_Q:   q_in  = wval;
            DST_RN:  rn_in = wval;
            DST_RD:  rd_in = wval;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      g_ff    <= g_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      flag_ff <= flag_in;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      dv_ff   <= dv_in;
      cnt_ff  <= cnt_in;
      mul_ff  <= mul_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign dp_status.unit_busy = busy_ff;
   assign dp_status.a_zero    = (an_ff == '0);
   assign dp_status.b_zero    = (bn_ff == '0);
   assign dp_status.a_inf     = (an_ff == INF_W) && (ad_ff == WORD_BITS'(1));
   assign dp_status.b_inf     = (bn_ff == INF_W) && (bd_ff == WORD_BITS'(1));
   assign dp_status.rn_zero   = (rn_ff == '0);
   assign dp_status.rd_zero   = (rd_ff == '0);
   assign dp_status.q_zero    = (q_ff == '0);
   assign dp_status.p_ge_q    = (p_ff >= q_ff);
   assign dp_status.q_ge_p    = (q_ff >= p_ff);
   assign dp_status.rn_fits   = (rn_ff[WD-1:WORD_BITS] == '0);
   assign dp_status.rd_fits   = (rd_ff[WD-1:WORD_BITS] == '0);

   assign res_num   = DATA_BITS'(rn_ff[WORD_BITS-1:0]);
   assign res_den   = DATA_BITS'(rd_ff[WORD_BITS-1:0]);
   assign res_flag  = flag_ff;
   assign res_error = err_ff;

endmodule

// ===== design/rau_ctrl.sv =====
// Controller: sequences multiplies, divisions and Euclid loops for each command.
module rau_ctrl import rau_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CMD_BITS-1:0] req_cmd,
   input  dp_status_type       dp_status,
   output dp_cmd_type          dp_cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_MK_CHECK, S_MK_PQ, S_GCD, S_WAIT, S_MK_DN, S_MK_DD,
      S_ADD_M1, S_ADD_M2, S_ADD_M3, S_ADD_FIT, S_ADD_DN, S_ADD_DD, S_ADD_FIT2,
      S_MUL_G1, S_MUL_D1, S_MUL_D2, S_MUL_G2, S_MUL_D3, S_MUL_D4, S_MUL_P1, S_MUL_P2,
      S_MUL_FIT, S_CMP_M1, S_CMP_M2, S_CMP_END, S_ZERO, S_INF, S_ERR, S_DONE
   } state_type;

   typedef enum logic [1:0] {R_MK, R_ADD, R_MUL1, R_MUL2} ret_type;

   state_type  state_ff, state_in, nxt_ff, nxt_in;
   ret_type    ret_ff, ret_in;
   cmd_type    cmd_ff, cmd_in;
   dp_cmd_type fin_ff, fin_in;
   logic       busy_ff, rsp_valid_ff;
   logic       leq_ab, leq_ba;

   function automatic dp_cmd_type mk(input dp_op_type op, input src_type a, input src_type b,
                                     input dst_type d, input logic v);
      dp_cmd_type c;
      c.op    = op;
      c.src_a = a;
      c.src_b = b;
      c.dst   = d;
      c.val   = v;
      return c;
   endfunction

   // With both cross products in p = bn*ad and q = an*bd.
   assign leq_ab = dp_status.a_zero || dp_status.b_inf ||
                   (!dp_status.a_inf && dp_status.p_ge_q);
   assign leq_ba = dp_status.b_zero || dp_status.a_inf ||
                   (!dp_status.b_inf && dp_status.q_ge_p);

   always_comb begin
      state_in = state_ff;
      nxt_in   = nxt_ff;
      ret_in   = ret_ff;
      cmd_in   = cmd_ff;
      fin_in   = fin_ff;
      dp_cmd   = mk(DP_NOP, SRC_AN, SRC_AN, DST_RN, 1'b0);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_cmd);
               dp_cmd   = mk(DP_LOAD, SRC_AN, SRC_AN, DST_RN, 1'b0);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_MAKE, CMD_SIMPLIFY: begin
                  dp_cmd   = mk(DP_TAKE, SRC_AN, SRC_AN, DST_RN, 1'b0);
                  state_in = S_MK_CHECK;
               end
               CMD_ADD: begin
                  if (dp_status.a_zero) begin
                     dp_cmd   = mk(DP_TAKE, SRC_AN, SRC_AN, DST_RN, 1'b1);
                     state_in = S_DONE;
                  end else if (dp_status.b_zero) begin
                     dp_cmd   = mk(DP_TAKE, SRC_AN, SRC_AN, DST_RN, 1'b0);
                     state_in = S_DONE;
                  end else if (dp_status.a_inf || dp_status.b_inf) begin
                     state_in = S_INF;
                  end else begin
                     state_in = S_ADD_M1;
                  end
               end
               CMD_MUL: begin
                  if (dp_status.a_zero || dp_status.b_zero) begin
                     state_in = S_ZERO;
                  end else if (dp_status.a_inf || dp_status.b_inf) begin
                     state_in = S_INF;
                  end else begin
                     state_in = S_MUL_G1;
                  end
               end
               CMD_LEQ, CMD_EQ, CMD_MAX: state_in = S_CMP_M1;
               default: state_in = S_ERR;
            endcase
         end
         S_MK_CHECK: begin
            // Simplify lets a zero denominator through: x/0 reduces to 1/0.
            if (dp_status.rd_zero && (cmd_ff != CMD_SIMPLIFY)) begin
               state_in = S_ERR;
            end else if (dp_status.rn_zero) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_MK_PQ;
            end
         end
         S_MK_PQ: begin
            dp_cmd   = mk(DP_LOAD_PQ, SRC_RN, SRC_RD, DST_RN, 1'b0);
            ret_in   = R_MK;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (dp_status.q_zero) begin
               dp_cmd = mk(DP_GCD_OUT, SRC_P, SRC_P, DST_RN, 1'b0);
               case (ret_ff)
                  R_MK:    state_in = S_MK_DN;
                  R_ADD:   state_in = S_ADD_DN;
                  R_MUL1:  state_in = S_MUL_D1;
                  R_MUL2:  state_in = S_MUL_D3;
                  default: state_in = S_MK_DN;
               endcase
            end else begin
               dp_cmd   = mk(DP_DIV, SRC_P, SRC_Q, DST_RN, 1'b0);
               fin_in   = mk(DP_EUCLID, SRC_P, SRC_Q, DST_RN, 1'b0);
               nxt_in   = S_GCD;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!dp_status.unit_busy) begin
               dp_cmd   = fin_ff;
               state_in = nxt_ff;
            end
         end
         S_MK_DN: begin
            dp_cmd   = mk(DP_DIV, SRC_RN, SRC_G, DST_RN, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_RN, SRC_G, DST_RN, 1'b0);
            nxt_in   = S_MK_DD;
            state_in = S_WAIT;
         end
         S_MK_DD: begin
            dp_cmd   = mk(DP_DIV, SRC_RD, SRC_G, DST_RD, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_RD, SRC_G, DST_RD, 1'b0);
            nxt_in   = S_DONE;
            state_in = S_WAIT;
         end
         S_ADD_M1: begin
            dp_cmd   = mk(DP_MUL, SRC_AN, SRC_BD, DST_RN, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_AN, SRC_BD, DST_RN, 1'b0);
            nxt_in   = S_ADD_M2;
            state_in = S_WAIT;
         end
         S_ADD_M2: begin
            dp_cmd   = mk(DP_MUL, SRC_BN, SRC_AD, DST_RN, 1'b0);
            fin_in   = mk(DP_ADD_PROD, SRC_RN, SRC_AD, DST_RN, 1'b0);
            nxt_in   = S_ADD_M3;
            state_in = S_WAIT;
         end
         S_ADD_M3: begin
            dp_cmd   = mk(DP_MUL, SRC_AD, SRC_BD, DST_RD, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_AD, SRC_BD, DST_RD, 1'b0);
            nxt_in   = S_ADD_FIT;
            state_in = S_WAIT;
         end
         S_ADD_FIT: begin
            if (dp_status.rn_fits && dp_status.rd_fits) begin
               state_in = S_MK_CHECK;
            end else begin
               dp_cmd   = mk(DP_LOAD_PQ, SRC_RN, SRC_RD, DST_RN, 1'b0);
               ret_in   = R_ADD;
               state_in = S_GCD;
            end
         end
         S_ADD_DN: begin
            dp_cmd   = mk(DP_DIV, SRC_RN, SRC_G, DST_RN, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_RN, SRC_G, DST_RN, 1'b0);
            nxt_in   = S_ADD_DD;
            state_in = S_WAIT;
         end
         S_ADD_DD: begin
            dp_cmd   = mk(DP_DIV, SRC_RD, SRC_G, DST_RD, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_RD, SRC_G, DST_RD, 1'b0);
            nxt_in   = S_ADD_FIT2;
            state_in = S_WAIT;
         end
         S_ADD_FIT2: begin
            state_in = (dp_status.rn_fits && dp_status.rd_fits) ? S_MK_CHECK : S_INF;
         end
         S_MUL_G1: begin
            dp_cmd   = mk(DP_LOAD_PQ, SRC_AN, SRC_BD, DST_RN, 1'b0);
            ret_in   = R_MUL1;
            state_in = S_GCD;
         end
         S_MUL_D1: begin
            dp_cmd   = mk(DP_DIV, SRC_AN, SRC_G, DST_AN, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_AN, SRC_G, DST_AN, 1'b0);
            nxt_in   = S_MUL_D2;
            state_in = S_WAIT;
         end
         S_MUL_D2: begin
            dp_cmd   = mk(DP_DIV, SRC_BD, SRC_G, DST_BD, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_BD, SRC_G, DST_BD, 1'b0);
            nxt_in   = S_MUL_G2;
            state_in = S_WAIT;
         end
         S_MUL_G2: begin
            dp_cmd   = mk(DP_LOAD_PQ, SRC_BN, SRC_AD, DST_RN, 1'b0);
            ret_in   = R_MUL2;
            state_in = S_GCD;
         end
         S_MUL_D3: begin
            dp_cmd   = mk(DP_DIV, SRC_BN, SRC_G, DST_BN, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_BN, SRC_G, DST_BN, 1'b0);
            nxt_in   = S_MUL_D4;
            state_in = S_WAIT;
         end
         S_MUL_D4: begin
            dp_cmd   = mk(DP_DIV, SRC_AD, SRC_G, DST_AD, 1'b0);
            fin_in   = mk(DP_MOVE_QUO, SRC_AD, SRC_G, DST_AD, 1'b0);
            nxt_in   = S_MUL_P1;
            state_in = S_WAIT;
         end
         S_MUL_P1: begin
            dp_cmd   = mk(DP_MUL, SRC_AN, SRC_BN, DST_RN, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_AN, SRC_BN, DST_RN, 1'b0);
            nxt_in   = S_MUL_P2;
            state_in = S_WAIT;
         end
         S_MUL_P2: begin
            dp_cmd   = mk(DP_MUL, SRC_AD, SRC_BD, DST_RD, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_AD, SRC_BD, DST_RD, 1'b0);
            nxt_in   = S_MUL_FIT;
            state_in = S_WAIT;
         end
         S_MUL_FIT: begin
            state_in = (dp_status.rn_fits && dp_status.rd_fits) ? S_MK_CHECK : S_INF;
         end
         S_CMP_M1: begin
            dp_cmd   = mk(DP_MUL, SRC_BN, SRC_AD, DST_P, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_BN, SRC_AD, DST_P, 1'b0);
            nxt_in   = S_CMP_M2;
            state_in = S_WAIT;
         end
         S_CMP_M2: begin
            dp_cmd   = mk(DP_MUL, SRC_AN, SRC_BD, DST_Q, 1'b0);
            fin_in   = mk(DP_MOVE_PROD, SRC_AN, SRC_BD, DST_Q, 1'b0);
            nxt_in   = S_CMP_END;
            state_in = S_WAIT;
         end
         S_CMP_END: begin
            case (cmd_ff)
               CMD_LEQ: dp_cmd = mk(DP_SET_FLAG, SRC_AN, SRC_AN, DST_RN, leq_ab);
               CMD_EQ:  dp_cmd = mk(DP_SET_FLAG, SRC_AN, SRC_AN, DST_RN, leq_ab && leq_ba);
               default: dp_cmd = mk(DP_TAKE, SRC_AN, SRC_AN, DST_RN, leq_ab);
            endcase
            state_in = S_DONE;
         end
         S_ZERO: begin
            dp_cmd   = mk(DP_SET_ZERO, SRC_AN, SRC_AN, DST_RN, 1'b0);
            state_in = S_DONE;
         end
         S_INF: begin
            dp_cmd   = mk(DP_SET_INF, SRC_AN, SRC_AN, DST_RN, 1'b0);
            state_in = S_DONE;
         end
         S_ERR: begin
            dp_cmd   = mk(DP_SET_ERR, SRC_AN, SRC_AN, DST_RN, 1'b0);
            state_in = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ret_ff <= ret_in;
      fin_ff <= fin_in;
      nxt_ff <= nxt_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_DONE);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   channel   direction  handshake                ports
//   request   in         start && !busy           req_cmd, req_a_*, req_b_*
//   response  out        rsp_valid, one cycle     rsp_res_num, rsp_res_den, rsp_flag, rsp_error
//
// One word is in flight at a time; busy stays high from acceptance until the response cycle.
// Multiplies and divisions both run on the one shared shift-add unit, and a gcd costs one
// division per Euclid step; the shortest words are additions with a zero operand and the
// longest are reductions of wide sums.
// Reset is synchronous; it idles the controller and the shared unit.
// The response is shown for one cycle only and is never held back.
module rational_arith_unit import rau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_BITS-1:0]  req_cmd,
   input  logic [DATA_BITS-1:0] req_a_num,
   input  logic [DATA_BITS-1:0] req_a_den,
   input  logic [DATA_BITS-1:0] req_b_num,
   input  logic [DATA_BITS-1:0] req_b_den,
   output logic                 rsp_valid,
   output logic [DATA_BITS-1:0] rsp_res_num,
   output logic [DATA_BITS-1:0] rsp_res_den,
   output logic                 rsp_flag,
   output logic                 rsp_error
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rau_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .dp_status (dp_status),
      .res_num   (rsp_res_num),
      .res_den   (rsp_res_den),
      .res_flag  (rsp_flag),
      .res_error (rsp_error)
   );

endmodule

// ===== design/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [DATA_BITS-1:0] rsp_res_num,
   input logic [DATA_BITS-1:0] rsp_res_den,
   input logic                 rsp_flag,
   input logic                 rsp_error
);

   // An accepted word keeps the unit busy until its response.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_rsp_in_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_rsp_frees, clock, reset, rsp_valid, !busy && !rsp_valid)
   `ASSERT_IMPLIES(a_err_clean, clock, reset, rsp_valid && rsp_error,
                   rsp_res_num == '0 && rsp_res_den == '0 && !rsp_flag)
   `ASSERT_IMPLIES(a_flag_clean, clock, reset, rsp_valid && rsp_flag,
                   rsp_res_num == '0 && rsp_res_den == '0 && !rsp_error)

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_res_num (rsp_res_num),
   .rsp_res_den (rsp_res_den),
   .rsp_flag    (rsp_flag),
   .rsp_error   (rsp_error)
);

// ===== sim/tb_rational_arith_unit.sv =====
// Self-checking testbench of the rational arithmetic unit with a built-in fraction predictor.
`timescale 1ns / 100ps

module tb_rational_arith_unit import rau_pkg::*;;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
   localparam logic [63:0] INF_WORD = {64{1'b1}};

   typedef struct {
      logic [63:0] num;
      logic [63:0] den;
      logic        flag;
      logic        err;
   } fraction_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_BITS-1:0]  req_cmd = '0;
   logic [DATA_BITS-1:0] req_a_num = '0;
   logic [DATA_BITS-1:0] req_a_den = '0;
   logic [DATA_BITS-1:0] req_b_num = '0;
   logic [DATA_BITS-1:0] req_b_den = '0;
   logic                 rsp_valid;
   logic [DATA_BITS-1:0] rsp_res_num;
   logic [DATA_BITS-1:0] rsp_res_den;
   logic                 rsp_flag;
   logic                 rsp_error;

   fraction_type pending_results[$];
   int           fail_count = 0;
   bit           idling_on = 1'b1;

   rational_arith_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_flag(rsp_flag), .rsp_error(rsp_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1500ms;
      $display("rational_arith_unit: mismatch");
      $finish;
   end

   function automatic logic [128:0] euclid(logic [128:0] x, logic [128:0] y);
      logic [128:0] t;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      return x;
   endfunction

   function automatic fraction_type frac(logic [63:0] n, logic [63:0] d);
      fraction_type r;
      r.num = n;
      r.den = d;
      r.flag = 1'b0;
      r.err = 1'b0;
      return r;
   endfunction

   function automatic fraction_type normalize(logic [63:0] n, logic [63:0] d);
      logic [128:0] g;
      fraction_type r;
      if (d == 0) begin
         r = frac(0, 0);
         r.err = 1'b1;
         return r;
      end
      if (n == 0) return frac(0, 1);
      g = euclid(n, d);
      return frac(n / g[63:0], d / g[63:0]);
   endfunction

   function automatic bit is_infinite(logic [63:0] n, logic [63:0] d);
      return n == INF_WORD && d == 1;
   endfunction

   function automatic bit less_or_equal(logic [63:0] an, logic [63:0] ad,
                                        logic [63:0] bn, logic [63:0] bd);
      logic [127:0] lhs, rhs;
      if (an == 0 || is_infinite(bn, bd)) return 1'b1;
      if (is_infinite(an, ad)) return 1'b0;
      lhs = {64'd0, an} * {64'd0, bd};
      rhs = {64'd0, bn} * {64'd0, ad};
      return lhs <= rhs;
   endfunction

   function automatic fraction_type sum_of(logic [63:0] an, logic [63:0] ad,
                                           logic [63:0] bn, logic [63:0] bd);
      logic [128:0] n, d, g;
      if (an == 0) return frac(bn, bd);
      if (bn == 0) return frac(an, ad);
      if (is_infinite(an, ad) || is_infinite(bn, bd)) return frac(INF_WORD, 1);
      n = {65'd0, an} * {65'd0, bd} + {65'd0, bn} * {65'd0, ad};
      d = {65'd0, ad} * {65'd0, bd};
      if (n > INF_WORD || d > INF_WORD) begin
         // A zero denominator leaves the gcd equal to the sum, so it reduces to 1/0 and is reported as an error.
         g = euclid(d, n);
         n = n / g;
         d = d / g;
         if (n > INF_WORD || d > INF_WORD) return frac(INF_WORD, 1);
      end
      return normalize(n[63:0], d[63:0]);
   endfunction

   function automatic fraction_type product_of(logic [63:0] an, logic [63:0] ad,
                                               logic [63:0] bn, logic [63:0] bd);
      logic [128:0] g1, g2, pn, pd;
      if (an == 0 || bn == 0) return frac(0, 1);
      if (is_infinite(an, ad) || is_infinite(bn, bd)) return frac(INF_WORD, 1);
      g1 = euclid(an, bd);
      g2 = euclid(bn, ad);
      pn = (an / g1) * (bn / g2);
      pd = (ad / g2) * (bd / g1);
      if (pn > INF_WORD || pd > INF_WORD) return frac(INF_WORD, 1);
      return normalize(pn[63:0], pd[63:0]);
   endfunction

   function automatic fraction_type predict_result(logic [CMD_BITS-1:0] cmd,
         logic [63:0] an, logic [63:0] ad, logic [63:0] bn, logic [63:0] bd);
      fraction_type r;
      logic [128:0] g;
      r = frac(0, 0);
      case (cmd)
         CMD_MAKE: r = normalize(an, ad);
         CMD_SIMPLIFY: begin
            if (an == 0) r = frac(0, 1);
            else begin
               g = euclid(an, ad);
               r = frac(an / g[63:0], ad / g[63:0]);
            end
         end
         CMD_ADD: r = sum_of(an, ad, bn, bd);
         CMD_MUL: r = product_of(an, ad, bn, bd);
         CMD_LEQ: r.flag = less_or_equal(an, ad, bn, bd);
         CMD_EQ: r.flag = less_or_equal(an, ad, bn, bd) && less_or_equal(bn, bd, an, ad);
         CMD_MAX: r = less_or_equal(an, ad, bn, bd) ? frac(bn, bd) : frac(an, ad);
         default: r.err = 1'b1;
      endcase
      return r;
   endfunction

   // Sends one word, records its expected result at acceptance, then maybe idles.
   task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [63:0] an, logic [63:0] ad,
                            logic [63:0] bn, logic [63:0] bd);
      int gap;
      start <= 1'b1;
      req_cmd <= cmd;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_result(cmd, an, ad, bn, bd));
      if (idling_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 11);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      fraction_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: num %h den %h", rsp_res_num, rsp_res_den);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_res_num !== e.num) begin
               $error("res_num expected %h actual %h", e.num, rsp_res_num);
               fail_count++;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den expected %h actual %h", e.den, rsp_res_den);
               fail_count++;
            end
            if (rsp_flag !== e.flag) begin
               $error("flag expected %b actual %b", e.flag, rsp_flag);
               fail_count++;
            end
            if (rsp_error !== e.err) begin
               $error("error expected %b actual %b", e.err, rsp_error);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [63:0] pick_value();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return INF_WORD;
         3, 4: return $urandom_range(1, 200);
         5: return w >> $urandom_range(1, 63);
         default: return w;
      endcase
   endfunction

   task automatic test_directed();
      logic [63:0] top;
      top = 64'h8000_0000_0000_0000;
      send_word(CMD_MAKE, 12, 18, 0, 0);
      send_word(CMD_MAKE, 5, 0, 0, 0);
      send_word(CMD_MAKE, 0, 7, 0, 0);
      send_word(CMD_MAKE, INF_WORD, INF_WORD, 0, 0);
      send_word(CMD_SIMPLIFY, 9, 0, 0, 0);
      send_word(CMD_SIMPLIFY, 0, 0, 0, 0);
      send_word(CMD_SIMPLIFY, 48, 36, 1, 1);
      send_word(CMD_ADD, 0, 0, 3, 0);
      send_word(CMD_ADD, 3, 4, 0, 5);
      send_word(CMD_ADD, INF_WORD, 1, 1, 2);
      send_word(CMD_ADD, 1, 6, 1, 3);
      send_word(CMD_ADD, INF_WORD, 2, INF_WORD, 3);
      send_word(CMD_ADD, top, 3, top, 3);
      send_word(CMD_ADD, 1, top, 1, top);
      send_word(CMD_ADD, 1, 0, 1, 0);
      send_word(CMD_MUL, 0, 5, INF_WORD, 1);
      send_word(CMD_MUL, INF_WORD, 1, 2, 3);
      send_word(CMD_MUL, 4, 9, 3, 8);
      send_word(CMD_MUL, top, 1, 4, 1);
      send_word(CMD_MUL, 2, 0, 3, 5);
      send_word(CMD_LEQ, 1, 3, 1, 2);
      send_word(CMD_LEQ, INF_WORD, 1, 5, 1);
      send_word(CMD_EQ, 2, 4, 3, 6);
      send_word(CMD_MAX, 1, 3, 1, 2);
      send_word(CMD_UNUSED, INF_WORD, INF_WORD, INF_WORD, INF_WORD);
   endtask

   task automatic test_random(int count);
      logic [CMD_BITS-1:0] cmd;
      for (int i = 0; i < count; i++) begin
         cmd = $urandom_range(0, 13) == 0 ? CMD_UNUSED : CMD_BITS'($urandom_range(0, 6));
         send_word(cmd, pick_value(), pick_value(), pick_value(), pick_value());
      end
   endtask

   initial begin
      int waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(520);
      idling_on = 1'b0;
      test_random(110);
      start <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("rational_arith_unit: match");
      end else begin
         $display("rational_arith_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arith_unit.sv
design/rau_checker.sv
sim/tb_rational_arith_unit.sv
